FILE: src/stl_pkg.sv
// Shared types, constants and helper functions for the symbol table unit.
package stl_pkg;

   localparam int MAX_LOG2  = 12;
   localparam int INIT_LOG2 = 3;
   localparam int RESET_LOG2 = (INIT_LOG2 > MAX_LOG2) ? MAX_LOG2 : INIT_LOG2;

   localparam int IDX_W  = MAX_LOG2;
   localparam int ADDR_W = IDX_W + 1;
   localparam int CNT_W  = IDX_W + 1;
   localparam int LG_W   = $clog2(MAX_LOG2 + 2);
   localparam int SLOT_W = 12;
   localparam int DEPTH  = 1 << ADDR_W;

   localparam logic [1:0] STAT_FOUND    = 2'd0;
   localparam logic [1:0] STAT_INSERTED = 2'd1;
   localparam logic [1:0] STAT_FULL     = 2'd2;

   typedef struct packed {
      logic [31:0] key;
      logic [31:0] key_hash;
      logic [31:0] new_handle;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [31:0]       handle;
      logic [SLOT_W-1:0] slot;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] key;
      logic [31:0] key_hash;
      logic [31:0] handle;
   } entry_type;

   typedef struct packed {
      logic              en;
      logic              we;
      logic [ADDR_W-1:0] addr;
      entry_type         wdata;
   } mem_req_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_PRD, ST_PCHK, ST_GCLR,
      ST_SRD, ST_SCHK, ST_GRD, ST_GCHK, ST_OUT
   } state_type;

   function automatic logic [IDX_W:0] cap_of(input logic [LG_W-1:0] lg);
      return (IDX_W+1)'(1) << lg;
   endfunction

   function automatic logic [IDX_W-1:0] mask_of(input logic [LG_W-1:0] lg);
      logic [IDX_W:0] c;
      c = cap_of(lg) - (IDX_W+1)'(1);
      return c[IDX_W-1:0];
   endfunction

endpackage

FILE: src/stl_ram.sv
// Single-port slot memory with registered read data, both banks in one array.
module stl_ram (
   input  logic                 clock,
   input  stl_pkg::mem_req_type mem_req,
   output stl_pkg::entry_type   rdata
);
   import stl_pkg::*;

   entry_type mem [DEPTH];
   entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.en) begin
         if (mem_req.we) begin
            mem[mem_req.addr] <= mem_req.wdata;
         end
         rdata_ff <= mem[mem_req.addr];
      end
   end

   assign rdata = rdata_ff;
endmodule

FILE: src/stl_ctrl.sv
// Probe, insert and grow sequencer for the symbol table.
module stl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  stl_pkg::req_type     req_data,
   output logic                 busy,
   output logic                 res_valid,
   output stl_pkg::rsp_type     res_data,
   input  logic                 res_ready,
   output stl_pkg::mem_req_type mem_req,
   input  stl_pkg::entry_type   rdata
);
   import stl_pkg::*;

   state_type         state_ff, state_in;
   logic [31:0]       key_ff, key_in;
   logic [31:0]       hash_ff, hash_in;
   logic [31:0]       handle_ff, handle_in;
   logic [IDX_W-1:0]  i_ff, i_in;
   logic [IDX_W:0]    n_ff, n_in;
   logic [IDX_W:0]    clr_ff, clr_in;
   logic [IDX_W:0]    src_ff, src_in;
   logic [LG_W-1:0]   lg_ff, lg_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              bank_ff, bank_in;
   logic              match_ff, match_in;
   entry_type         ent_ff, ent_in;
   rsp_type           res_ff, res_in;

   logic [IDX_W:0]    cap_cur, cap_new;
   logic [IDX_W-1:0]  mask_cur, mask_new;
   logic [IDX_W:0]    step_sum;
   logic [CNT_W:0]    count_next;
   logic              over_half;
   logic              src_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         lg_ff    <= LG_W'(RESET_LOG2);
         count_ff <= '0;
         bank_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         lg_ff    <= lg_in;
         count_ff <= count_in;
         bank_ff  <= bank_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      hash_ff   <= hash_in;
      handle_ff <= handle_in;
      i_ff      <= i_in;
      n_ff      <= n_in;
      src_ff    <= src_in;
      match_ff  <= match_in;
      ent_ff    <= ent_in;
      res_ff    <= res_in;
   end

   assign cap_cur    = cap_of(lg_ff);
   assign cap_new    = cap_of(lg_ff + LG_W'(1));
   assign mask_cur   = mask_of(lg_ff);
   assign mask_new   = mask_of(lg_ff + LG_W'(1));
   assign step_sum   = {1'b0, i_ff} + n_ff + (IDX_W+1)'(1);
   assign count_next = {1'b0, count_ff} + (CNT_W+1)'(1);
   assign over_half  = count_next > (CNT_W+1)'(cap_cur >> 1);
   assign src_last   = (src_ff + (IDX_W+1)'(1)) == cap_cur;

   assign busy      = (state_ff != ST_IDLE);
   assign res_valid = (state_ff == ST_OUT);
   assign res_data  = res_ff;

   always_comb begin
      state_in  = state_ff;
      key_in    = key_ff;
      hash_in   = hash_ff;
      handle_in = handle_ff;
      i_in      = i_ff;
      n_in      = n_ff;
      clr_in    = clr_ff;
      src_in    = src_ff;
      lg_in     = lg_ff;
      count_in  = count_ff;
      bank_in   = bank_ff;
      match_in  = match_ff;
      ent_in    = ent_ff;
      res_in    = res_ff;
      mem_req   = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_req.en    = 1'b1;
            mem_req.we    = 1'b1;
            mem_req.addr  = {1'b0, clr_ff[IDX_W-1:0]};
            clr_in        = clr_ff + (IDX_W+1)'(1);
            if (clr_in == cap_cur) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               key_in    = req_data.key;
               hash_in   = req_data.key_hash;
               handle_in = req_data.new_handle;
               i_in      = req_data.key_hash[IDX_W-1:0] & mask_cur;
               n_in      = '0;
               match_in  = 1'b1;
               state_in  = ST_PRD;
            end
         end
         ST_PRD: begin
            mem_req.en   = 1'b1;
            mem_req.addr = {bank_ff, i_ff};
            state_in     = ST_PCHK;
         end
         ST_PCHK: begin
            state_in = ST_OUT;
            if (!rdata.valid) begin
               if (over_half) begin
                  if (lg_ff >= LG_W'(MAX_LOG2)) begin
                     res_in = '{status: STAT_FULL, handle: '0, slot: '0};
                  end else begin
                     clr_in   = '0;
                     state_in = ST_GCLR;
                  end
               end else begin
                  mem_req.en    = 1'b1;
                  mem_req.we    = 1'b1;
                  mem_req.addr  = {bank_ff, i_ff};
                  mem_req.wdata = '{valid: 1'b1, key: key_ff, key_hash: hash_ff,
                                    handle: handle_ff};
                  count_in      = count_next[CNT_W-1:0];
                  res_in        = '{status: STAT_INSERTED, handle: handle_ff,
                                    slot: SLOT_W'(i_ff)};
               end
            end else if (match_ff && rdata.key == key_ff) begin
               res_in = '{status: STAT_FOUND, handle: rdata.handle, slot: SLOT_W'(i_ff)};
            end else if ((n_ff + (IDX_W+1)'(1)) == cap_cur) begin
               res_in = '{status: STAT_FULL, handle: '0, slot: '0};
            end else begin
               i_in     = step_sum[IDX_W-1:0] & mask_cur;
               n_in     = n_ff + (IDX_W+1)'(1);
               state_in = ST_PRD;
            end
         end
         ST_GCLR: begin
            // Empty the used part of the other bank before copying into it.
            mem_req.en   = 1'b1;
            mem_req.we   = 1'b1;
            mem_req.addr = {~bank_ff, clr_ff[IDX_W-1:0]};
            clr_in       = clr_ff + (IDX_W+1)'(1);
            if (clr_in == cap_new) begin
               src_in   = '0;
               state_in = ST_SRD;
            end
         end
         ST_SRD: begin
            mem_req.en   = 1'b1;
            mem_req.addr = {bank_ff, src_ff[IDX_W-1:0]};
            state_in     = ST_SCHK;
         end
         ST_SCHK, ST_GCHK: begin
            if (state_ff == ST_SCHK && rdata.valid) begin
               ent_in   = rdata;
               i_in     = rdata.key_hash[IDX_W-1:0] & mask_new;
               n_in     = '0;
               state_in = ST_GRD;
            end else if (state_ff == ST_GCHK && rdata.valid &&
                         (n_ff + (IDX_W+1)'(1)) != cap_new) begin
               i_in     = step_sum[IDX_W-1:0] & mask_new;
               n_in     = n_ff + (IDX_W+1)'(1);
               state_in = ST_GRD;
            end else begin
               if (state_ff == ST_GCHK && !rdata.valid) begin
                  mem_req.en    = 1'b1;
                  mem_req.we    = 1'b1;
                  mem_req.addr  = {~bank_ff, i_ff};
                  mem_req.wdata = ent_ff;
               end
               if (src_last) begin
                  // Copy complete: switch banks and place the pending key.
                  bank_in  = ~bank_ff;
                  lg_in    = lg_ff + LG_W'(1);
                  match_in = 1'b0;
                  i_in     = hash_ff[IDX_W-1:0] & mask_new;
                  n_in     = '0;
                  state_in = ST_PRD;
               end else begin
                  src_in   = src_ff + (IDX_W+1)'(1);
                  state_in = ST_SRD;
               end
            end
         end
         ST_GRD: begin
            mem_req.en   = 1'b1;
            mem_req.addr = {~bank_ff, i_ff};
            state_in     = ST_GCHK;
         end
         ST_OUT: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule

FILE: src/symbol_table_lookup_or_insert_unit.sv
// Top level of the symbol table lookup-or-insert unit.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  key, key_hash, new_handle
//   rsp      out        rsp_valid/rsp_stall  status, handle, slot
//
// Each probe is a memory read, then a compare; the probes of a request run one
// after another through the single-port slot memory, which sets their pace.
// A growth sweeps 2 * old capacity entries to clear, then reads each old slot
// and re-probes every valid entry.
// After reset the first 2^INIT_LOG2 slots of bank zero are cleared, one per cycle,
// while req_stall is held high. The result register lets a new request be
// accepted while the previous result is still stalled on the rsp side.
module symbol_table_lookup_or_insert_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  stl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output stl_pkg::rsp_type rsp_data
);
   import stl_pkg::*;

   mem_req_type mem_req;
   entry_type   rdata;
   logic        busy;
   logic        res_valid;
   rsp_type     res_data;
   logic        res_ready;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   stl_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (rdata)
   );

   stl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .busy      (busy),
      .res_valid (res_valid),
      .res_data  (res_data),
      .res_ready (res_ready),
      .mem_req   (mem_req),
      .rdata     (rdata)
   );

   // The result register is free when empty or when its transfer completes now.
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_refuse_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STAT_FULL |-> rsp_data.handle == '0 &&
      rsp_data.slot == '0)
      else $error("refused result carries nonzero handle or slot");

   a_busy_after_take : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request transfer not followed by busy");

   a_rsp_from_busy : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a request in work");
`endif
endmodule

FILE: test/symbol_table_lookup_or_insert_checker.sv
// Watches both channels of the symbol table unit, predicts each result and compares it.
module symbol_table_lookup_or_insert_checker
   import stl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count,
   output int      full_count,
   output int      grow_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BANK = 1 << MAX_LOG2;

   typedef enum {PROBE_HIT, PROBE_EMPTY, PROBE_NONE} probe_kind_type;

   logic [31:0] table_key    [2*BANK];
   logic [31:0] table_hash   [2*BANK];
   logic [31:0] table_handle [2*BANK];
   bit          table_used   [2*BANK];
   int          entries;
   int          size_log2;
   int          live_bank;
   rsp_type     expected_rsp [$];

   function automatic probe_kind_type probe_bank(int b, int lg, logic [31:0] k,
                                                 logic [31:0] h, bit match, output int s);
      int cap;
      int i;
      int idx;
      cap = 1 << lg;
      i = h & (cap - 1);
      s = 0;
      for (int n = 0; n < cap; n++) begin
         idx = b * BANK + i;
         if (!table_used[idx]) begin
            s = i;
            return PROBE_EMPTY;
         end
         if (match && table_key[idx] == k) begin
            s = i;
            return PROBE_HIT;
         end
         i = (i + n + 1) & (cap - 1);
      end
      return PROBE_NONE;
   endfunction

   function automatic void rehash_into_other_bank();
      int dst;
      int src;
      int j;
      dst = live_bank ^ 1;
      for (int i = 0; i < BANK; i++) table_used[dst*BANK + i] = 0;
      for (int i = 0; i < (1 << size_log2); i++) begin
         src = live_bank * BANK + i;
         if (table_used[src] &&
             probe_bank(dst, size_log2 + 1, 0, table_hash[src], 0, j) == PROBE_EMPTY) begin
            table_used[dst*BANK + j]   = 1;
            table_key[dst*BANK + j]    = table_key[src];
            table_hash[dst*BANK + j]   = table_hash[src];
            table_handle[dst*BANK + j] = table_handle[src];
         end
      end
      live_bank = dst;
      size_log2++;
      grow_count++;
   endfunction

   function automatic rsp_type lookup_or_insert(req_type r);
      rsp_type        res;
      probe_kind_type kind;
      int             s;
      kind = probe_bank(live_bank, size_log2, r.key, r.key_hash, 1, s);
      if (kind == PROBE_HIT) begin
         res.status = STAT_FOUND;
         res.handle = table_handle[live_bank*BANK + s];
         res.slot   = SLOT_W'(s);
         return res;
      end
      if (kind == PROBE_EMPTY && entries + 1 > ((1 << size_log2) >> 1)) begin
         if (size_log2 >= MAX_LOG2) begin
            kind = PROBE_NONE;
         end else begin
            rehash_into_other_bank();
            kind = probe_bank(live_bank, size_log2, r.key, r.key_hash, 0, s);
         end
      end
      if (kind != PROBE_EMPTY) begin
         res.status = STAT_FULL;
         res.handle = '0;
         res.slot   = '0;
         full_count++;
         return res;
      end
      table_used[live_bank*BANK + s]   = 1;
      table_key[live_bank*BANK + s]    = r.key;
      table_hash[live_bank*BANK + s]   = r.key_hash;
      table_handle[live_bank*BANK + s] = r.new_handle;
      entries++;
      res.status = STAT_INSERTED;
      res.handle = r.new_handle;
      res.slot   = SLOT_W'(s);
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < 2*BANK; i++) table_used[i] = 0;
         entries = 0;
         size_log2 = RESET_LOG2;
         live_bank = 0;
         expected_rsp.delete();
         fail_count = 0;
         full_count = 0;
         grow_count = 0;
      end else begin
         if (req_valid && !req_stall) expected_rsp.push_back(lookup_or_insert(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result %p", rsp_data);
            end else begin
               want = expected_rsp.pop_front();
               if (want.status !== rsp_data.status || want.handle !== rsp_data.handle ||
                   want.slot !== rsp_data.slot) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected status %0d handle %h slot %0d, got %0d %h %0d",
                              want.status, want.handle, want.slot,
                              rsp_data.status, rsp_data.handle, rsp_data.slot);
               end
            end
         end
      end
      pending_count = expected_rsp.size();
   end

endmodule

FILE: test/symbol_table_lookup_or_insert_unit_tb.sv
// Stimulus and verdict for the symbol table lookup-or-insert unit.
module symbol_table_lookup_or_insert_unit_tb;
   import stl_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // Generous ceiling: every transfer may wait out random idle gaps on both sides,
   // each probe costs a memory read and a compare, and each growth sweeps the whole table.
   localparam int CYCLE_LIMIT = 2_000_000;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   req_type req_data = '0;
   logic    req_stall;
   logic    rsp_valid;
   logic    rsp_stall = 1;
   rsp_type rsp_data;

   int fail_count;
   int pending_count;
   int full_count;
   int grow_count;
   int cycle_count = 0;
   int sent_count = 0;
   bit calm_phase = 0;

   // Keys already sent, so that later transfers can look them up again.
   logic [31:0] known_key  [$];
   logic [31:0] known_hash [$];
   logic [31:0] fresh_key = 32'h4000_0000;

   symbol_table_lookup_or_insert_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   symbol_table_lookup_or_insert_checker watcher (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count),
      .full_count(full_count), .grow_count(grow_count)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // The watchdog ends a hung run with the failure verdict.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb: failure");
         $finish;
      end
   end

   // Idle gap for one transfer; calm stretches run with no gaps at all.
   function automatic int draw_gap();
      return calm_phase ? 0 : $urandom_range(0, 17);
   endfunction

   // Send one request. Valid stays high across back-to-back transfers, and
   // stall is checked at the falling edge, where the block holds it steady.
   task automatic send_request(logic [31:0] k, logic [31:0] h, logic [31:0] hd);
      int gap;
      gap = draw_gap();
      repeat (gap) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data  <= '{key: k, key_hash: h, new_handle: hd};
      forever begin
         @(negedge clock);
         if (!req_stall) break;
      end
      @(posedge clock);
      known_key.push_back(k);
      known_hash.push_back(h);
      sent_count++;
      if (sent_count % 150 == 0) calm_phase = !calm_phase;
   endtask

   task automatic send_fresh(logic [31:0] h);
      fresh_key = fresh_key + 1;
      send_request(fresh_key, h, $urandom());
   endtask

   task automatic send_known_lookup();
      int n;
      n = $urandom_range(0, known_key.size() - 1);
      send_request(known_key[n], known_hash[n], $urandom());
   endtask

   // The result side stalls for a random gap before each transfer, and not at all in calm stretches.
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_stall <= 1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 0;
         forever begin
            @(negedge clock);
            if (rsp_valid) break;
         end
         @(posedge clock);
      end
   end

   initial begin
      logic [31:0] h;
      int choice;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part: field extremes, hits on both, colliding hashes that force
      // triangular probing, a miss that shares a hash, and the first growth.
      send_request(32'h0, 32'h0, 32'h0);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(32'h0, 32'h0, 32'h1234_5678);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      for (int i = 1; i <= 6; i++) send_request(32'h100 + i, 32'h0, 32'hA5A5_0000 + i);
      send_request(32'h0000_0200, 32'h0, 32'h5A5A_5A5A);
      for (int i = 1; i <= 6; i++) send_request(32'h100 + i, 32'h0, 32'h0);
      send_request(32'h8000_0000, 32'h8000_0007, 32'h8000_0000);
      send_request(32'h7FFF_FFFF, 32'h7FFF_FFF8, 32'h7FFF_FFFF);
      send_request(32'h8000_0000, 32'h8000_0007, 32'h0);

      // Random part: mostly lookups of keys already sent and fresh inserts,
      // with a share of hashes crowded into a few clusters.
      repeat (905) begin
         choice = $urandom_range(0, 9);
         if (choice < 4) begin
            send_known_lookup();
         end else if (choice < 8) begin
            send_fresh($urandom());
         end else if (choice < 9) begin
            h = $urandom_range(0, 3) << 5;
            send_fresh(h);
         end else begin
            send_request($urandom(), $urandom(), $urandom());
         end
      end

      // Close with lookups of keys already present and a few fresh inserts.
      repeat (20) send_known_lookup();
      repeat (5) send_fresh($urandom());
      req_valid <= 0;

      wait (pending_count == 0);
      repeat (100) @(posedge clock);

      $display("covered %0d requests, %0d table growths and %0d refused inserts",
               sent_count, grow_count, full_count);
      $display("finished in %0d cycles with %0d mismatches", cycle_count, fail_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
